>>> design/btla_pkg.sv
// package for the bakery ticket lock arbiter
// request and response types, function and status codes; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package btla_pkg;

  localparam int unsigned ActiveBits  = 5;
  localparam int unsigned ClientBits  = 4;
  localparam int unsigned StatusBits  = 3;
  localparam int unsigned GivenBits   = 16;
  localparam int unsigned EntryBits   = 32;
  localparam logic [ActiveBits-1:0] ActiveReset = 5'd16;

  typedef enum logic {
    FUNC_REQUEST = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_e;

  typedef enum logic [StatusBits-1:0] {
    STATUS_OK         = 3'd0,
    STATUS_HELD       = 3'd1,
    STATUS_NOT_HOLDER = 3'd2,
    STATUS_OVERFLOW   = 3'd3,
    STATUS_INACTIVE   = 3'd4
  } status_e;

  typedef struct packed {
    logic                  func;
    logic [ClientBits-1:0] client;
  } req_t;

  typedef struct packed {
    logic [StatusBits-1:0] status;
    logic                  holder_valid;
    logic [ClientBits-1:0] holder;
    logic [GivenBits-1:0]  ticket_given;
    logic [EntryBits-1:0]  client_entries;
  } rsp_t;

endpackage

`default_nettype wire

>>> design/bakery_ticket_lock_arbiter_core.sv
// bakery ticket lock arbiter top level: sequencer, ticket and entry memories
// uses btla_pkg, btla_ram and btla_scan
//
// usage:
//   req channel (req_valid_i / req_ready_o / req_i) carries one request or
//   release per item: func and client. every item gives exactly one response
//   on the rsp channel (rsp_valid_o / rsp_ready_i / rsp_o): status, holder
//   after the step, ticket handed out and the client's entry count.
//   cfg channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the number of
//   active clients; it is always ready and should be written while idle.
// timing:
//   one item at a time. tickets live in a one-port-read memory that is
//   scanned one entry per cycle over the n active clients (at most CLIENTS),
//   and a successful release scans a second time to find the new holder.
//   the response turns valid when the core returns to idle.
// reset:
//   all tickets and entry counts read as zero (per-entry valid flops), 16
//   active clients. a stalled receiver holds the response in the output
//   register; the next item is still taken and waits only at its end.
`timescale 1ns / 1ps
`default_nettype none

module bakery_ticket_lock_arbiter_core #(
  parameter int unsigned CLIENTS     = 16,
  parameter int unsigned TICKET_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [4:0]             cfg_data_i,
  input  wire logic                   req_valid_i,
  output logic                        req_ready_o,
  input  wire btla_pkg::req_t         req_i,
  output logic                        rsp_valid_o,
  input  wire logic                   rsp_ready_i,
  output btla_pkg::rsp_t              rsp_o
);

  import btla_pkg::*;

  localparam int unsigned AW = $clog2(CLIENTS);
  localparam int unsigned CW = $clog2(CLIENTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_RESCAN,
    S_FINISH
  } state_e;

  state_e                  state_q;
  logic [ActiveBits-1:0]   active_q;
  logic [CW-1:0]           n_q;
  logic [CW-1:0]           n_d;
  logic                    func_q;
  logic [ClientBits-1:0]   cli_q;
  rsp_t                    res_q;
  rsp_t                    rsp_q;
  logic                    rsp_valid_q;

  logic [CLIENTS-1:0]      tv_q;
  logic [CLIENTS-1:0]      ev_q;
  logic                    tvr_q;
  logic                    evr_q;

  logic                    req_fire;
  logic                    scan_start;
  logic                    scan_done;
  logic                    found;
  logic [AW-1:0]           who;
  logic [TICKET_BITS-1:0]  mx;
  logic [TICKET_BITS-1:0]  own;
  logic [AW-1:0]           raddr;
  logic [AW-1:0]           cli_addr;
  logic [TICKET_BITS-1:0]  t_rdata;
  logic [TICKET_BITS-1:0]  t_val;
  logic [TICKET_BITS-1:0]  t_wdata;
  logic                    t_we;
  logic [EntryBits-1:0]    e_rdata;
  logic [EntryBits-1:0]    e_val;
  logic [EntryBits-1:0]    e_next;
  logic                    e_we;

  logic                    inactive;
  logic                    req_ok;
  logic                    rel_ok;
  logic [TICKET_BITS-1:0]  new_ticket;
  logic [AW-1:0]           post_who;
  logic [7:0]              post_who8;
  logic [7:0]              who8;
  logic [31:0]             given32;
  logic [2:0]              status_sel;

  assign cfg_ready_o = 1'b1;
  assign req_ready_o = (state_q == S_IDLE);
  assign req_fire    = req_valid_i && req_ready_o;
  assign cli_addr    = AW'(cli_q);

  always_comb begin
    if (active_q > CLIENTS) begin
      n_d = CW'(CLIENTS);
    end else begin
      n_d = CW'(active_q);
    end
  end

  // item classification, valid in S_UPDATE
  assign inactive   = (cli_q >= n_q);
  assign new_ticket = mx + TICKET_BITS'(1);
  assign req_ok     = !inactive && (func_q == FUNC_REQUEST) && (own == '0) && !(&mx);
  assign rel_ok     = !inactive && (func_q == FUNC_RELEASE) && found && (who == cli_addr);
  assign e_val      = evr_q ? e_rdata : '0;
  assign e_next     = e_val + EntryBits'(1);
  assign t_val      = tvr_q ? t_rdata : '0;

  always_comb begin
    status_sel = STATUS_OK;
    if (inactive) begin
      status_sel = STATUS_INACTIVE;
    end else if (func_q == FUNC_REQUEST) begin
      if (own != '0) begin
        status_sel = STATUS_HELD;
      end else if (&mx) begin
        status_sel = STATUS_OVERFLOW;
      end
    end else if (!rel_ok) begin
      status_sel = STATUS_NOT_HOLDER;
    end
  end

  // a new ticket is the largest, so the holder only changes when there was none
  assign post_who   = found ? who : cli_addr;
  assign post_who8  = 8'(post_who);
  assign who8       = 8'(who);
  assign given32    = 32'(new_ticket);

  assign t_we       = (state_q == S_UPDATE) && (req_ok || rel_ok);
  assign t_wdata    = req_ok ? new_ticket : '0;
  assign e_we       = (state_q == S_UPDATE) && rel_ok;
  assign scan_start = req_fire || e_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ActiveReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_q <= cfg_data_i;
    end
  end

  // valid flops stand in for the cleared reset contents of both memories
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q  <= '0;
      ev_q  <= '0;
      tvr_q <= 1'b0;
      evr_q <= 1'b0;
    end else begin
      tvr_q <= tv_q[raddr];
      evr_q <= ev_q[cli_addr];
      if (t_we) begin
        tv_q[cli_addr] <= 1'b1;
      end
      if (e_we) begin
        ev_q[cli_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      func_q      <= 1'b0;
      cli_q       <= '0;
      res_q       <= '0;
      rsp_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp_ready_i && (state_q != S_FINISH)) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            n_q     <= n_d;
            func_q  <= req_i.func;
            cli_q   <= req_i.client;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          res_q.status         <= status_sel;
          res_q.ticket_given   <= req_ok ? given32[GivenBits-1:0] : '0;
          res_q.client_entries <= (cli_q < CLIENTS) ? (rel_ok ? e_next : e_val) : '0;
          if (req_ok) begin
            res_q.holder_valid <= 1'b1;
            res_q.holder       <= post_who8[ClientBits-1:0];
          end else begin
            res_q.holder_valid <= found;
            res_q.holder       <= found ? who8[ClientBits-1:0] : '0;
          end
          state_q <= rel_ok ? S_RESCAN : S_FINISH;
        end
        S_RESCAN: begin
          if (scan_done) begin
            res_q.holder_valid <= found;
            res_q.holder       <= found ? who8[ClientBits-1:0] : '0;
            state_q            <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!rsp_valid_q || rsp_ready_i) begin
            rsp_q       <= res_q;
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  btla_scan #(
    .CLIENTS     (CLIENTS),
    .TICKET_BITS (TICKET_BITS)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scan_start),
    .count_i  (n_q),
    .client_i (cli_addr),
    .rdata_i  (t_val),
    .raddr_o  (raddr),
    .done_o   (scan_done),
    .found_o  (found),
    .who_o    (who),
    .max_o    (mx),
    .own_o    (own)
  );

  btla_ram #(
    .WIDTH (TICKET_BITS),
    .DEPTH (CLIENTS)
  ) u_ticket_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (cli_addr),
    .wdata_i (t_wdata),
    .raddr_i (raddr),
    .rdata_o (t_rdata)
  );

  btla_ram #(
    .WIDTH (EntryBits),
    .DEPTH (CLIENTS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (cli_addr),
    .wdata_i (e_next),
    .raddr_i (cli_addr),
    .rdata_o (e_rdata)
  );

endmodule

`default_nettype wire

>>> design/btla_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module btla_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/btla_scan.sv
// ticket scan unit: walks the ticket memory one entry a cycle, finding the
// largest ticket, the holder (smallest nonzero ticket) and the client's ticket
`timescale 1ns / 1ps
`default_nettype none

module btla_scan #(
  parameter int unsigned CLIENTS     = 16,
  parameter int unsigned TICKET_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [$clog2(CLIENTS+1)-1:0] count_i,
  input  wire logic [$clog2(CLIENTS)-1:0]   client_i,
  input  wire logic [TICKET_BITS-1:0]       rdata_i,
  output logic      [$clog2(CLIENTS)-1:0]   raddr_o,
  output logic                              done_o,
  output logic                              found_o,
  output logic      [$clog2(CLIENTS)-1:0]   who_o,
  output logic      [TICKET_BITS-1:0]       max_o,
  output logic      [TICKET_BITS-1:0]       own_o
);

  localparam int unsigned AW = $clog2(CLIENTS);
  localparam int unsigned CW = $clog2(CLIENTS + 1);

  logic                   busy_q;
  logic [CW-1:0]          cnt_q;
  logic                   pv_q;
  logic [AW-1:0]          pidx_q;
  logic                   found_q;
  logic [AW-1:0]          who_q;
  logic [TICKET_BITS-1:0] best_q;
  logic [TICKET_BITS-1:0] max_q;
  logic [TICKET_BITS-1:0] own_q;
  logic                   issue;

  assign issue = busy_q && (cnt_q < count_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      pv_q   <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      pv_q   <= 1'b0;
    end else if (busy_q) begin
      pv_q <= issue;
      if (issue) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (!issue && !pv_q) begin
        busy_q <= 1'b0;
      end
    end
  end

  // read data lines up with pidx_q in the cycle after the address
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      found_q <= 1'b0;
      who_q   <= '0;
      best_q  <= '0;
      max_q   <= '0;
      own_q   <= '0;
    end else begin
      pidx_q <= cnt_q[AW-1:0];
      if (busy_q && pv_q) begin
        if (rdata_i > max_q) begin
          max_q <= rdata_i;
        end
        // strict compare keeps the lowest index among equal tickets
        if ((rdata_i != '0) && (!found_q || (rdata_i < best_q))) begin
          found_q <= 1'b1;
          best_q  <= rdata_i;
          who_q   <= pidx_q;
        end
        if (pidx_q == client_i) begin
          own_q <= rdata_i;
        end
      end
    end
  end

  assign raddr_o = cnt_q[AW-1:0];
  assign done_o  = busy_q && !issue && !pv_q;
  assign found_o = found_q;
  assign who_o   = who_q;
  assign max_o   = max_q;
  assign own_o   = own_q;

endmodule

`default_nettype wire

>>> sim/btla_lock_checker.sv
// lock checker: follows the cfg, req and rsp channels of the bakery lock arbiter,
// predicts each response from its own ticket and entry tables and compares field by field
// depends on btla_pkg
`timescale 1ns / 1ps

module btla_lock_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [4:0]        cfg_data_i,
  input  logic              req_valid_i,
  input  logic              req_ready_i,
  input  btla_pkg::req_t    req_i,
  input  logic              rsp_valid_i,
  input  logic              rsp_ready_i,
  input  btla_pkg::rsp_t    rsp_i,
  output int                mismatch_count_o,
  output int                awaited_count_o
);
  import btla_pkg::*;

  localparam int unsigned Clients = 16;

  logic [15:0]        ticket_mem [Clients];
  logic [EntryBits-1:0] entry_mem [Clients];
  logic [ActiveBits-1:0] active_reg;
  rsp_t               awaited_rsp [$];

  // smallest nonzero ticket among the active clients, lowest index on a tie
  function automatic void lock_owner(input logic [4:0] n, output logic found,
                                     output logic [ClientBits-1:0] who);
    logic [15:0] best;
    found = 1'b0;
    best  = '0;
    who   = '0;
    for (int i = 0; i < n; i++) begin
      if (ticket_mem[i] != '0 && (!found || ticket_mem[i] < best)) begin
        found = 1'b1;
        best  = ticket_mem[i];
        who   = 4'(i);
      end
    end
  endfunction

  function automatic rsp_t bakery_predict(input req_t r);
    rsp_t                  res;
    logic [4:0]            n;
    logic [15:0]           top_ticket;
    logic                  found;
    logic [ClientBits-1:0] who;
    n   = (active_reg > 5'd16) ? 5'd16 : active_reg;
    res = '0;
    res.status = STATUS_OK;
    if ({1'b0, r.client} >= n) begin
      res.status = STATUS_INACTIVE;
    end else if (r.func == FUNC_REQUEST) begin
      if (ticket_mem[r.client] != '0) begin
        res.status = STATUS_HELD;
      end else begin
        top_ticket = '0;
        for (int i = 0; i < n; i++) begin
          if (ticket_mem[i] > top_ticket) top_ticket = ticket_mem[i];
        end
        if (top_ticket == '1) begin
          res.status = STATUS_OVERFLOW;
        end else begin
          ticket_mem[r.client] = top_ticket + 16'd1;
          res.ticket_given     = top_ticket + 16'd1;
        end
      end
    end else begin
      lock_owner(n, found, who);
      if (!found || who != r.client) begin
        res.status = STATUS_NOT_HOLDER;
      end else begin
        ticket_mem[r.client] = '0;
        entry_mem[r.client]  = entry_mem[r.client] + 32'd1;
      end
    end
    lock_owner(n, found, who);
    res.holder_valid   = found;
    res.holder         = found ? who : '0;
    res.client_entries = entry_mem[r.client];
    return res;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Clients; i++) begin
        ticket_mem[i] = '0;
        entry_mem[i]  = '0;
      end
      active_reg = ActiveReset;
      awaited_rsp.delete();
      mismatch_count_o = 0;
      awaited_count_o <= 0;
    end else begin
      // the response side goes first: a request taken at the same edge is not answered yet
      if (rsp_valid_i && rsp_ready_i) begin
        if (awaited_rsp.size() == 0) begin
          $error("response with no request outstanding: status %0d", rsp_i.status);
          mismatch_count_o++;
        end else begin
          want = awaited_rsp.pop_front();
          check_field("status", want.status, rsp_i.status);
          check_field("holder_valid", want.holder_valid, rsp_i.holder_valid);
          check_field("holder", want.holder, rsp_i.holder);
          check_field("ticket_given", want.ticket_given, rsp_i.ticket_given);
          check_field("client_entries", want.client_entries, rsp_i.client_entries);
        end
      end
      if (req_valid_i && req_ready_i) awaited_rsp.push_back(bakery_predict(req_i));
      if (cfg_valid_i && cfg_ready_i) active_reg = cfg_data_i;
      awaited_count_o <= awaited_rsp.size();
    end
  end

endmodule

>>> sim/testbench.sv
// testbench top for bakery_ticket_lock_arbiter_core: clock, reset, request traffic,
// response stalls and the verdict; checking is done by btla_lock_checker
// depends on btla_pkg, btla_lock_checker and the arbiter rtl
`timescale 1ns / 1ps

module testbench;
  import btla_pkg::*;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [4:0] cfg_data  = '0;
  logic       req_valid = 1'b0;
  req_t       req       = '0;
  logic       rsp_ready = 1'b0;
  logic       cfg_ready;
  logic       req_ready;
  logic       rsp_valid;
  rsp_t       rsp;
  int         mismatches;
  int         awaited;

  logic [ClientBits-1:0] holder_hint = '0;
  bit                    steady      = 1'b0;
  int                    burst_left  = 0;
  int                    ready_left  = 0;
  int                    active_now  = 16;

  int phase_active [10] = '{3, 16, 1, 2, 31, 0, 7, 20, 5, 12};

  always #5 clk = ~clk;

  bakery_ticket_lock_arbiter_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp)
  );

  btla_lock_checker lock_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .req_valid_i      (req_valid),
    .req_ready_i      (req_ready),
    .req_i            (req),
    .rsp_valid_i      (rsp_valid),
    .rsp_ready_i      (rsp_ready),
    .rsp_i            (rsp),
    .mismatch_count_o (mismatches),
    .awaited_count_o  (awaited)
  );

  // receiver: short stalls, short and long ready runs
  always @(posedge clk) begin
    if (steady) begin
      rsp_ready <= 1'b1;
    end else if (ready_left == 0) begin
      if (rsp_ready) begin
        rsp_ready <= 1'b0;
        ready_left = $urandom_range(1, 6);
      end else begin
        rsp_ready <= 1'b1;
        ready_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 10);
      end
    end else begin
      ready_left--;
    end
  end

  // last reported holder steers releases toward ones that succeed
  always @(posedge clk) begin
    if (rsp_valid && rsp_ready) begin
      holder_hint <= rsp.holder_valid ? rsp.holder : 4'($urandom_range(0, 15));
    end
  end

  task automatic send_op(input func_e f, input logic [ClientBits-1:0] c);
    req_t item;
    item.func   = f;
    item.client = c;
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (!steady) begin
      if (burst_left == 0) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 45)) @(posedge clk);
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(0, 6);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_active(input logic [4:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    active_now = v;
    @(posedge clk);
  endtask

  task automatic random_op();
    func_e           f;
    logic [ClientBits-1:0] c;
    int              n;
    n = (active_now > 16) ? 16 : active_now;
    f = func_e'($urandom_range(0, 1));
    if (f == FUNC_RELEASE && $urandom_range(0, 99) < 65) begin
      c = holder_hint;
    end else if (n > 0 && $urandom_range(0, 99) < 85) begin
      c = 4'($urandom_range(0, n - 1));
    end else begin
      c = 4'($urandom_range(0, 15));
    end
    send_op(f, c);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // basic request and release rules with all clients active
    send_op(FUNC_RELEASE, 4'd0);
    send_op(FUNC_REQUEST, 4'd0);
    send_op(FUNC_REQUEST, 4'd0);
    send_op(FUNC_REQUEST, 4'd15);
    send_op(FUNC_RELEASE, 4'd15);
    send_op(FUNC_RELEASE, 4'd0);
    send_op(FUNC_REQUEST, 4'd0);
    send_op(FUNC_RELEASE, 4'd15);
    send_op(FUNC_RELEASE, 4'd0);
    // single client, then none at all
    write_active(5'd1);
    send_op(FUNC_REQUEST, 4'd1);
    send_op(FUNC_REQUEST, 4'd0);
    send_op(FUNC_RELEASE, 4'd0);
    write_active(5'd0);
    send_op(FUNC_REQUEST, 4'd0);
    send_op(FUNC_RELEASE, 4'd15);
    // tickets left behind by clients that drop out of the active range
    write_active(5'd16);
    send_op(FUNC_REQUEST, 4'd5);
    send_op(FUNC_REQUEST, 4'd7);
    write_active(5'd4);
    send_op(FUNC_REQUEST, 4'd2);
    send_op(FUNC_RELEASE, 4'd5);
    send_op(FUNC_RELEASE, 4'd2);
    // count above the client total is clamped
    write_active(5'd31);
    send_op(FUNC_RELEASE, 4'd7);
    send_op(FUNC_RELEASE, 4'd5);
    send_op(FUNC_RELEASE, 4'd7);

    // two clients leapfrog back to back with the receiver always ready
    write_active(5'd2);
    steady = 1'b1;
    send_op(FUNC_REQUEST, 4'd0);
    send_op(FUNC_REQUEST, 4'd1);
    for (int i = 0; i < 12; i++) begin
      send_op(FUNC_RELEASE, 4'(i % 2));
      send_op(FUNC_REQUEST, 4'(i % 2));
    end
    send_op(FUNC_RELEASE, 4'd0);
    send_op(FUNC_REQUEST, 4'd0);
    send_op(FUNC_RELEASE, 4'd0);
    wait_drained();
    steady = 1'b0;

    for (int p = 0; p < 10; p++) begin
      write_active(5'(phase_active[p]));
      for (int k = 0; k < ((phase_active[p] == 0) ? 20 : 120); k++) begin
        if ($urandom_range(0, 59) == 0) wait_drained();
        random_op();
      end
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #(64'd10_000_000);
    $display("testbench: errors");
    $finish;
  end

endmodule
